@@ hw/rtl/glob_pkg.sv @@
// Shared types, constants and the star-closure scan for the glob matcher.
// No dependencies; used by glob_front, glob_back and the top level.
package glob_pkg;

  // Pattern capacity and derived widths
  localparam int PATTERN_MAX  = 32;
  localparam int LEN_W        = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W        = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CLOSE_LEVELS = $clog2(PATTERN_MAX + 1);

  // Decoupling queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item modes
  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_APPEND  = 2'd1;
  localparam logic [1:0] MODE_SUBJECT = 2'd2;
  localparam logic [1:0] MODE_END     = 2'd3;

  // Wildcard bytes
  localparam logic [7:0] STAR_CHAR = 8'd42;
  localparam logic [7:0] ANY_CHAR  = 8'd63;

  // One flag per pattern position, position PATTERN_MAX means "all consumed"
  typedef logic [PATTERN_MAX:0] pos_t;

  // Queued transaction, classified on entry
  typedef struct packed {
    logic       is_verdict;
    logic [1:0] mode;
    logic [7:0] char_value;
  } item_t;

  // Prefix scan: pos j is set if seed j is set, or j-1 is set and prop j holds.
  // prop[j] is the star flag of position j-1 (prop[0] is zero).
  function automatic pos_t close_stars(pos_t seed, pos_t prop);
    pos_t g;
    pos_t p;
    pos_t g_n;
    pos_t p_n;
    g = seed;
    p = prop;
    for (int lvl = 0; lvl < CLOSE_LEVELS; lvl++) begin
      g_n = g;
      p_n = p;
      for (int j = 0; j <= PATTERN_MAX; j++) begin
        if (j >= (1 << lvl)) begin
          g_n[j] = g[j] | (p[j] & g[j - (1 << lvl)]);
          p_n[j] = p[j] & p[j - (1 << lvl)];
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

endpackage

@@ hw/rtl/glob_front.sv @@
// Front part of the glob matcher: accepts input transactions, classifies
// them and holds them in a short queue for the back part. Uses glob_pkg.
module glob_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_char_value,
  output logic                q_valid,
  output glob_pkg::item_t     q_item,
  input  logic                q_pop
);

  glob_pkg::item_t                  queue_r [glob_pkg::QUEUE_DEPTH];
  logic [glob_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [glob_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [glob_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             push;
  glob_pkg::item_t                  entry;

  // Stall only when the queue is full
  assign in_stall = (count_r == glob_pkg::QCNT_W'(glob_pkg::QUEUE_DEPTH));
  assign push     = in_valid & ~in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = queue_r[rd_ptr_r];

  // Classify the incoming transaction
  always_comb begin
    entry.is_verdict = (in_mode == glob_pkg::MODE_END);
    entry.mode       = in_mode;
    entry.char_value = in_char_value;
  end

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= glob_pkg::QCNT_W'(glob_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

@@ hw/rtl/glob_back.sv @@
// Back part of the glob matcher: pattern store, active-position tracking
// and the verdict output register. Uses glob_pkg.
module glob_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  glob_pkg::item_t     q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_match,
  output logic                out_pattern_overflow
);

  logic [7:0]                 store_r [glob_pkg::PATTERN_MAX];
  logic [glob_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                       ovf_r, ovf_nxt;
  glob_pkg::pos_t             seed_r, seed_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_match_r;
  logic                       out_ovf_r;
  logic                       out_free;
  logic                       store_we;

  logic [glob_pkg::PATTERN_MAX-1:0] in_range;
  logic [glob_pkg::PATTERN_MAX-1:0] is_star;
  logic [glob_pkg::PATTERN_MAX-1:0] hit_char;
  glob_pkg::pos_t             prop;
  glob_pkg::pos_t             act;
  glob_pkg::pos_t             step;
  glob_pkg::pos_t             seed_init;
  logic                       hit;

  assign out_free = ~out_valid_r | ~out_stall;
  assign q_pop    = q_valid & (~q_item.is_verdict | out_free);

  assign seed_init = glob_pkg::pos_t'(1);

  // Decode each pattern lane against the current subject byte
  always_comb begin
    prop = '0;
    for (int i = 0; i < glob_pkg::PATTERN_MAX; i++) begin
      in_range[i] = (glob_pkg::LEN_W'(i) < len_r);
      is_star[i]  = in_range[i] & (store_r[i] == glob_pkg::STAR_CHAR);
      hit_char[i] = in_range[i] & ~is_star[i]
                  & ((store_r[i] == glob_pkg::ANY_CHAR) || (store_r[i] == q_item.char_value));
      prop[i+1]   = is_star[i];
    end
  end

  // Close the stored seed set through star runs
  assign act = glob_pkg::close_stars(seed_r, prop);
  assign hit = act[len_r] & ~ovf_r;

  // Advance every active position by one subject byte
  always_comb begin
    step = '0;
    for (int i = 0; i < glob_pkg::PATTERN_MAX; i++) begin
      step[i]   = step[i] | (act[i] & is_star[i]);
      step[i+1] = act[i] & hit_char[i];
    end
  end

  // Execute the popped transaction
  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    seed_nxt      = seed_r;
    store_we      = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;
    if (q_pop) begin
      unique case (q_item.mode)
        glob_pkg::MODE_CLEAR: begin
          len_nxt  = '0;
          ovf_nxt  = 1'b0;
          seed_nxt = seed_init;
        end
        glob_pkg::MODE_APPEND: begin
          if (len_r < glob_pkg::LEN_W'(glob_pkg::PATTERN_MAX)) begin
            store_we = 1'b1;
            len_nxt  = len_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          seed_nxt = seed_init;
        end
        glob_pkg::MODE_SUBJECT: begin
          seed_nxt = step;
        end
        glob_pkg::MODE_END: begin
          seed_nxt      = seed_init;
          out_valid_nxt = 1'b1;
        end
        default: begin
          seed_nxt = seed_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      seed_r      <= seed_init;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Write pattern bytes and capture the verdict
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[len_r[glob_pkg::IDX_W-1:0]] <= q_item.char_value;
    end
    if (q_pop && q_item.is_verdict) begin
      out_match_r <= hit;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_match            = out_match_r;
  assign out_pattern_overflow = out_ovf_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= glob_pkg::LEN_W'(glob_pkg::PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(q_pop & q_item.is_verdict))
    else $error("verdict raised without an end-of-subject transaction");

  a_overflow_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.is_verdict && ovf_r) |=> (out_valid_r && !out_match_r && out_ovf_r))
    else $error("overflowed pattern produced a match");

  a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.mode == glob_pkg::MODE_CLEAR) |=> (len_r == '0 && seed_r == seed_init))
    else $error("clear did not restart pattern and subject");

endmodule

@@ hw/rtl/wildcard_glob_matcher_unit.sv @@
// Top level of the wildcard glob matcher: front queue plus matching engine.
// Depends on glob_pkg, glob_front and glob_back.
//
//   Port group   Direction  Handshake          Payload
//   in_*         input      in_valid/in_stall  in_mode[1:0], in_char_value[7:0]
//   out_*        output     out_valid/out_stall out_match, out_pattern_overflow
//
// One transaction per cycle is sustained unless out_stall holds back an
// end-of-subject transaction; in the matching engine all pattern positions
// update in parallel and the star closure is a registered-to-registered
// prefix scan. An accepted transaction is written into the queue before the
// engine pops it, and the verdict is captured in the output registers.
// Reset (rst_n low, synchronous) empties the queue, clears the pattern length,
// the overflow flag and the output valid; the pattern bytes are not cleared.
// out_stall holds the verdict and stalls only end-of-subject transactions;
// in_stall rises when the two-entry queue is full.
module wildcard_glob_matcher_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_char_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_match,
  output logic       out_pattern_overflow
);

  logic            q_valid;
  logic            q_pop;
  glob_pkg::item_t q_item;

  // Accept and queue transactions
  glob_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_char_value (in_char_value),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // Match against the stored pattern
  glob_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_match            (out_match),
    .out_pattern_overflow (out_pattern_overflow)
  );

endmodule
